// ===== rtl/core/cspa_pkg.sv =====
// cspa_pkg: shared types and codes of the chained slot pool allocator
// depends on nothing; used by the channel interfaces and the top level
package cspa_pkg;

    // fixed width of the slot fields of a request and a result
    localparam int FIELD_W = 6;

    // default pool size
    localparam int DEFAULT_SLOTS = 64;

    // request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic STAT_DONE  = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    // one request
    typedef struct packed {
        logic               action;
        logic               has_next;
        logic [FIELD_W-1:0] next_slot;
        logic [FIELD_W-1:0] freed_slot;
    } req_item_t;

    // one result
    typedef struct packed {
        logic [FIELD_W-1:0] slot;
        logic               status;
    } rsp_item_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/cspa_req_if.sv =====
// cspa_req_if: valid/ready channel that carries allocate and free requests
// depends on cspa_pkg for the request type
interface cspa_req_if;
    logic                 valid;
    logic                 ready;
    cspa_pkg::req_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cspa_rsp_if.sv =====
// cspa_rsp_if: valid/ready channel that carries allocator results
// depends on cspa_pkg for the result type
interface cspa_rsp_if;
    logic                 valid;
    logic                 ready;
    cspa_pkg::rsp_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/chained_slot_pool_allocator_top.sv =====
// chained_slot_pool_allocator_top: slot pool with a link memory and a free list
// depends on cspa_pkg, cspa_req_if and cspa_rsp_if
//
//  channel | dir | modport | payload
//  --------+-----+---------+------------------------------------------
//  req     | in  | sink    | action, has_next, next_slot, freed_slot
//  rsp     | out | source  | slot, status
//
// allocate: one link memory read and one write
// free: one link memory read per hop along a chain of L links
// after reset a clearing pass loads the initial free list;
// req is not ready during it
// a result sits in an output register until taken; the sequencer holds
// its last step while that register is still full
module chained_slot_pool_allocator_top #(
    parameter int SLOTS = cspa_pkg::DEFAULT_SLOTS
) (
    input  logic       clk,
    input  logic       rst_n,
    cspa_req_if.sink   req,
    cspa_rsp_if.source rsp
);
    import cspa_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int WIDE_W = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;
    localparam int CMP_W  = WIDE_W + 1;
    localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(SLOTS - 1);

    // link memory: bit IDX_W is the valid bit, the rest the linked slot
    logic [IDX_W:0] link_mem [SLOTS];
    logic [IDX_W:0] rdata_reg;

    state_t state_reg, state_next;

    logic             head_valid_reg, head_valid_next;
    logic [IDX_W-1:0] head_idx_reg, head_idx_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] hops_reg, hops_next;
    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;
    req_item_t        req_reg, req_next;
    logic             out_valid_reg, out_valid_next;
    rsp_item_t        out_data_reg, out_data_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W:0]   mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // decoded request and memory fields
    logic [CMP_W-1:0] freed_w, next_w, rd_idx_w, head_w;
    logic             freed_ok, next_ok, rd_cont, pool_empty, out_free, accept;

    assign freed_w    = CMP_W'(req.data.freed_slot);
    assign freed_ok   = (freed_w < SLOTS_C);
    assign next_w     = CMP_W'(req_reg.next_slot);
    assign next_ok    = req_reg.has_next && (next_w < SLOTS_C);
    assign rd_idx_w   = CMP_W'(rdata_reg[IDX_W-1:0]);
    assign rd_cont    = rdata_reg[IDX_W] && (rd_idx_w < SLOTS_C);
    assign head_w     = CMP_W'(head_idx_reg);
    assign pool_empty = !head_valid_reg || (head_w >= SLOTS_C);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (init_cnt_reg == LAST_C)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.action == ACT_ALLOC)
                        state_next = ST_ALLOC;
                    else if (freed_ok)
                        state_next = ST_WALK;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_ALLOC:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (!rd_cont || (hops_reg == LAST_C))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        req.ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = p_reg;
        mem_wdata       = '0;
        mem_raddr       = head_idx_reg;
        head_valid_next = head_valid_reg;
        head_idx_next   = head_idx_reg;
        p_next          = p_reg;
        hops_next       = hops_reg;
        init_cnt_next   = init_cnt_reg;
        req_next        = req_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        case (state_reg)
            ST_INIT:
            begin
                // clearing pass: slot i links to i+1, last slot to null
                mem_we        = 1'b1;
                mem_waddr     = init_cnt_reg;
                if (init_cnt_reg == LAST_C)
                    mem_wdata = '0;
                else
                    mem_wdata = {1'b1, init_cnt_reg + 1'b1};
                init_cnt_next = init_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                // read the head link, or the first link of a chain to free
                req.ready = 1'b1;
                if (req.valid && (req.data.action == ACT_FREE))
                    mem_raddr = freed_w[IDX_W-1:0];
                if (accept)
                begin
                    req_next  = req.data;
                    p_next    = freed_w[IDX_W-1:0];
                    hops_next = '0;
                end
            end
            ST_ALLOC:
            begin
                // pop the free head and set its link, or report an empty pool
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pool_empty)
                    begin
                        out_data_next.slot   = '0;
                        out_data_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        head_valid_next = rdata_reg[IDX_W];
                        head_idx_next   = rdata_reg[IDX_W-1:0];
                        mem_we          = 1'b1;
                        mem_waddr       = head_idx_reg;
                        mem_wdata       = next_ok ? {1'b1, next_w[IDX_W-1:0]} : '0;
                        out_data_next.slot   = head_w[FIELD_W-1:0];
                        out_data_next.status = STAT_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                // one hop per cycle; at the chain end splice in the free list, no splice past the hop limit
                mem_raddr = p_reg;
                if (rd_cont)
                begin
                    if (hops_reg != LAST_C)
                    begin
                        mem_raddr = rdata_reg[IDX_W-1:0];
                        p_next    = rdata_reg[IDX_W-1:0];
                        hops_next = hops_reg + 1'b1;
                    end
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = p_reg;
                    mem_wdata       = {head_valid_reg, head_idx_reg};
                    head_valid_next = 1'b1;
                    head_idx_next   = IDX_W'(req_reg.freed_slot);
                end
            end
            ST_FINISH:
            begin
                // free result, also for an ignored free
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.slot   = '0;
                    out_data_next.status = STAT_DONE;
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            init_cnt_reg   <= '0;
            head_valid_reg <= 1'b1;
            head_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            head_valid_reg <= head_valid_next;
            head_idx_reg   <= head_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        hops_reg     <= hops_next;
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    // link memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= link_mem[mem_raddr];
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench of chained_slot_pool_allocator_top
// depends on cspa_pkg, cspa_req_if, cspa_rsp_if and the allocator top level
module tb;
    import cspa_pkg::*;

    localparam int SLOTS          = DEFAULT_SLOTS;
    localparam int TAIL_CALM      = 100;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHAPED_ITEMS   = 800;
    localparam int NOISY_ITEMS    = 150;

    // one link of the pool: valid bit plus slot index
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] idx;
    } slot_link_t;

    // whole pool: every link plus the free head
    typedef struct packed {
        slot_link_t [SLOTS-1:0] links;
        slot_link_t             head;
    } pool_state_t;

    // request waiting for the driver; drain makes it wait for all results
    typedef struct {
        req_item_t req;
        bit        drain;
    } queued_req_t;

    logic clk = 1'b0;
    logic rst_n;

    cspa_req_if req_ch ();
    cspa_rsp_if rsp_ch ();

    chained_slot_pool_allocator_top #(
        .SLOTS (SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    queued_req_t        pending_reqs [$];
    rsp_item_t          rsp_expected [$];
    logic [FIELD_W-1:0] chain_heads [$];
    pool_state_t        pool_plan;
    pool_state_t        pool_now;
    int                 reqs_taken = 0;
    int                 total_reqs = 0;
    int                 errors = 0;
    int                 quiet_cycles = 0;
    int                 gap_left = 0;
    int                 stall_left = 0;
    logic               req_fire = 1'b0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pool after reset: one free list 0 -> 1 -> ... -> last -> null
    function automatic pool_state_t pool_after_reset();
        pool_state_t s;
        for (int i = 0; i < SLOTS; i++)
        begin
            s.links[i].valid = (i + 1 < SLOTS);
            s.links[i].idx   = (i + 1 < SLOTS) ? FIELD_W'(i + 1) : '0;
        end
        s.head.valid = 1'b1;
        s.head.idx   = '0;
        return s;
    endfunction

    // next pool state and result for one allocate or free request
    function automatic void pool_advance(input pool_state_t s_in, input req_item_t r,
                                         output pool_state_t s_out, output rsp_item_t o);
        pool_state_t        s;
        logic [FIELD_W-1:0] p;
        int                 hops;
        bit                 circular;
        s        = s_in;
        o.slot   = '0;
        o.status = STAT_DONE;
        if (r.action == ACT_ALLOC)
        begin
            if (!s.head.valid)
                o.status = STAT_EMPTY;
            else
            begin
                p                = s.head.idx;
                s.head           = s.links[p];
                s.links[p].valid = r.has_next;
                s.links[p].idx   = r.has_next ? r.next_slot : '0;
                o.slot           = p;
            end
        end
        else
        begin
            // walk to the chain end; give up on a circular chain
            p        = r.freed_slot;
            hops     = 0;
            circular = 1'b0;
            while (s.links[p].valid && !circular)
            begin
                if (hops >= SLOTS - 1)
                    circular = 1'b1;
                else
                begin
                    p    = s.links[p].idx;
                    hops = hops + 1;
                end
            end
            if (!circular)
            begin
                s.links[p]   = s.head;
                s.head.valid = 1'b1;
                s.head.idx   = r.freed_slot;
            end
        end
        s_out = s;
    endfunction

    // request with every field random
    function automatic req_item_t random_req();
        req_item_t r;
        r.action     = 1'($urandom_range(0, 1));
        r.has_next   = 1'($urandom_range(0, 1));
        r.next_slot  = FIELD_W'($urandom_range(0, SLOTS - 1));
        r.freed_slot = FIELD_W'($urandom_range(0, SLOTS - 1));
        return r;
    endfunction

    function automatic req_item_t make_req(input logic act, input logic nxt_en,
                                           input logic [FIELD_W-1:0] nxt,
                                           input logic [FIELD_W-1:0] freed);
        req_item_t r;
        r.action     = act;
        r.has_next   = nxt_en;
        r.next_slot  = nxt;
        r.freed_slot = freed;
        return r;
    endfunction

    // idling is off in the tail of the run and in every fourth stretch of 100
    function automatic bit idle_allowed();
        return pending_reqs.size() > TAIL_CALM && ((reqs_taken / 100) % 4) != 3;
    endfunction

    // queue a request and track the pool it leaves behind
    task automatic plan_request(input req_item_t r, input bit drain, output rsp_item_t o);
        pool_state_t nxt;
        queued_req_t q;
        pool_advance(pool_plan, r, nxt, o);
        pool_plan = nxt;
        q.req     = r;
        q.drain   = drain;
        pending_reqs.push_back(q);
    endtask

    // allocate a new chain, extend one, or free one, with random spare fields
    task automatic well_formed_step(input int alloc_pct, input bit drain);
        req_item_t r;
        rsp_item_t o;
        int        k;
        bit        linked;
        r      = random_req();
        linked = 1'b0;
        if (chain_heads.size() == 0 || $urandom_range(1, 100) <= alloc_pct)
        begin
            r.action   = ACT_ALLOC;
            r.has_next = 1'b0;
            if (chain_heads.size() > 0 && $urandom_range(0, 1))
            begin
                k           = $urandom_range(0, chain_heads.size() - 1);
                r.has_next  = 1'b1;
                r.next_slot = chain_heads[k];
                chain_heads.delete(k);
                linked      = 1'b1;
            end
            plan_request(r, drain, o);
            if (o.status == STAT_DONE)
                chain_heads.push_back(o.slot);
            else if (linked)
                chain_heads.push_back(r.next_slot);
        end
        else
        begin
            k            = $urandom_range(0, chain_heads.size() - 1);
            r.action     = ACT_FREE;
            r.freed_slot = chain_heads[k];
            chain_heads.delete(k);
            plan_request(r, drain, o);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(req_ch.valid && !req_fire))
            begin
                if (req_fire && idle_allowed() && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 3);
                if (gap_left > 0)
                begin
                    gap_left     = gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && rsp_expected.size() > 0))
                begin
                    req_ch.data  <= pending_reqs[0].req;
                    req_ch.valid <= 1'b1;
                    pending_reqs.pop_front();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
        else
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
    end

    // result ready with stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left   = stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
        else
            rsp_ch.ready <= 1'b0;
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        rsp_item_t   got;
        rsp_item_t   want;
        pool_state_t nxt;
        if (rst_n)
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.data;
                if (rsp_expected.size() == 0)
                begin
                    $error("result with none expected: slot %0d status %0d",
                           got.slot, got.status);
                    errors++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (got.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                pool_advance(pool_now, req_ch.data, nxt, want);
                pool_now = nxt;
                rsp_expected.push_back(want);
                reqs_taken++;
            end
            // watchdog on cycles without any handshake
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        rsp_item_t          o;
        logic [FIELD_W-1:0] s [8];
        int                 len;
        int                 pct;
        int                 pcts [4];
        rst_n        = 1'b0;
        pcts         = '{25, 50, 75, 97};
        pool_plan    = pool_after_reset();
        pool_now     = pool_after_reset();

        // directed: short chains, freeing them, a self loop, a longer chain
        plan_request(make_req(ACT_ALLOC, 1'b0, 6'd63, 6'd63), 1'b0, o);
        s[0] = o.slot;
        plan_request(make_req(ACT_ALLOC, 1'b1, s[0], 6'd0), 1'b0, o);
        s[1] = o.slot;
        plan_request(make_req(ACT_ALLOC, 1'b0, 6'd0, 6'd42), 1'b0, o);
        s[2] = o.slot;
        plan_request(make_req(ACT_FREE, 1'b1, 6'd63, s[1]), 1'b0, o);
        plan_request(make_req(ACT_FREE, 1'b0, 6'd21, s[2]), 1'b0, o);
        // slot linked to itself: the free of a circular chain is dropped
        plan_request(make_req(ACT_ALLOC, 1'b1, pool_plan.head.idx, 6'd63), 1'b0, o);
        s[3] = o.slot;
        plan_request(make_req(ACT_FREE, 1'b0, 6'd0, s[3]), 1'b0, o);
        plan_request(make_req(ACT_ALLOC, 1'b0, 6'd63, 6'd0), 1'b0, o);
        s[4] = o.slot;
        plan_request(make_req(ACT_ALLOC, 1'b1, s[4], 6'd63), 1'b0, o);
        s[5] = o.slot;
        plan_request(make_req(ACT_ALLOC, 1'b1, s[5], 6'd0), 1'b0, o);
        s[6] = o.slot;
        plan_request(make_req(ACT_FREE, 1'b1, 6'd0, s[6]), 1'b0, o);

        // fill the pool past empty, then episodes of varying allocate share
        for (int i = 0; i < 70; i++)
            well_formed_step(100, 1'b0);
        while (pending_reqs.size() < SHAPED_ITEMS)
        begin
            len = $urandom_range(20, 60);
            pct = pcts[$urandom_range(0, 3)];
            for (int i = 0; i < len; i++)
                well_formed_step(pct, 1'b0);
        end

        // misuse and noise mixed with well-formed traffic; first one drains
        for (int i = 0; i < NOISY_ITEMS; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) < 3)
                plan_request(random_req(), 1'b0, o);
            else
                well_formed_step(50, i == 0);
        end
        total_reqs = pending_reqs.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (reqs_taken == total_reqs);
        wait (rsp_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rsp_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", rsp_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
